>>> rtl/bfs_distance_engine_macros.svh
// Assertion macros shared by the RTL of the breadth-first search engine.
// No dependencies; the clock and reset of the including module are named clock and reset.
`ifndef BFS_DISTANCE_ENGINE_MACROS_SVH
`define BFS_DISTANCE_ENGINE_MACROS_SVH
`ifndef SYNTH
`define BDE_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
`define BDE_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("forbidden condition seen");
`else
`define BDE_ASSERT(lbl, prop)
`define BDE_NEVER(lbl, expr)
`endif
`endif

>>> rtl/bde_pkg.sv
// Package of the breadth-first search engine: sizes, codes and shared types.
// No dependencies.
package bde_pkg;
   localparam int MAX_NODES  = 1024;
   localparam int MAX_EDGES  = 4096;
   localparam int FIELD_W    = 11;
   localparam int NODE_IDX_W = $clog2(MAX_NODES);
   localparam int CNT_W      = $clog2(MAX_NODES + 1);
   localparam int EDGE_IDX_W = $clog2(MAX_EDGES);
   localparam int ETOT_W     = $clog2(MAX_EDGES + 1);
   localparam int CSR_ADDR_W = 3;

   localparam logic [FIELD_W-1:0] NODE_COUNT_RST  = FIELD_W'(1024);
   localparam logic [FIELD_W-1:0] SOURCE_NODE_RST = FIELD_W'(1);
   localparam logic [FIELD_W-1:0] ACTIVE_MAX      = FIELD_W'(MAX_NODES);
   localparam logic [FIELD_W-1:0] DIST_UNREACHABLE = '1;
   localparam logic [ETOT_W-1:0]  EDGE_TOTAL_MAX  = ETOT_W'(MAX_EDGES);
   localparam logic [CNT_W-1:0]   QUEUE_MAX       = CNT_W'(MAX_NODES);

   localparam logic REG_NODE_COUNT  = 1'b0;
   localparam logic REG_SOURCE_NODE = 1'b1;

   typedef enum logic [1:0] {
      KIND_ADD_EDGE = 2'd0,
      KIND_RUN      = 2'd1,
      KIND_READ     = 2'd2,
      KIND_CLEAR    = 2'd3
   } kind_type;

   typedef struct packed {
      logic [FIELD_W-1:0] node_count;
      logic [FIELD_W-1:0] source_node;
   } cfg_type;
endpackage

>>> rtl/bfs_distance_engine.sv
// Top level of the breadth-first search engine: edge table, distance store and queue.
// Depends on bde_pkg, bde_csr and bfs_distance_engine_macros.svh.
//
//   channel  | direction | transaction
//   req_*    | in        | one command: add edge, run, read distance or clear edges
//   rsp_*    | out       | one result per command: distance, reached count, status
//   csr_*    | in/out    | APB-style register access to node_count and source_node
//
// Add edge, clear edges and a read of a bad node complete in the cycle of acceptance; a good
// read passes ST_READ, as the distance memory has a registered read port, and then ST_DONE.
// A run first sweeps the whole distance memory, then walks the queue: ST_POP and ST_POPW
// pop a node and ST_CURD fetches its distance; each stored edge then takes ST_EREAD and
// ST_EWAIT, plus ST_HCHK when it leaves the popped node; single-port memories set this.
// After reset the same sweep marks every node unreachable; no command is accepted meanwhile,
// though register writes are.
// A result waits in the output register until it is taken; the next command is accepted only
// while the output register is being emptied or already empty.
`include "bfs_distance_engine_macros.svh"
module bfs_distance_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_kind,
   input  logic [bde_pkg::FIELD_W-1:0]          req_from_node,
   input  logic [bde_pkg::FIELD_W-1:0]          req_to_node,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [bde_pkg::FIELD_W-1:0]   rsp_distance,
   output logic [bde_pkg::FIELD_W-1:0]          rsp_reached_count,
   output logic                                 rsp_status,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bde_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   localparam int NW = bde_pkg::NODE_IDX_W;
   localparam int FW = bde_pkg::FIELD_W;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_READ, ST_DONE, ST_CLR, ST_SEED, ST_POP, ST_POPW,
      ST_CURD, ST_EREAD, ST_EWAIT, ST_HCHK
   } state_type;

   bde_pkg::cfg_type cfg;

   bde_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Memories: distances, the frontier queue and the edge table (tail and head, less one).
   logic [FW-1:0]   dist_mem [bde_pkg::MAX_NODES];
   logic [NW-1:0]   queue_mem [bde_pkg::MAX_NODES];
   logic [2*NW-1:0] edge_mem [bde_pkg::MAX_EDGES];

   logic                             dist_we, queue_we, edge_we;
   logic [NW-1:0]                    dist_addr, queue_addr;
   logic [bde_pkg::EDGE_IDX_W-1:0]   edge_addr;
   logic [FW-1:0]                    dist_wdata, dist_rdata_ff;
   logic [NW-1:0]                    queue_wdata, queue_rdata_ff;
   logic [2*NW-1:0]                  edge_wdata, edge_rdata_ff;

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_addr] <= dist_wdata;
      end
      dist_rdata_ff <= dist_mem[dist_addr];
   end

   always_ff @(posedge clock) begin
      if (queue_we) begin
         queue_mem[queue_addr] <= queue_wdata;
      end
      queue_rdata_ff <= queue_mem[queue_addr];
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_addr] <= edge_wdata;
      end
      edge_rdata_ff <= edge_mem[edge_addr];
   end

   state_type                   state_ff, state_in;
   logic [NW-1:0]               sweep_ff, sweep_in;
   logic [bde_pkg::ETOT_W-1:0]  edge_total_ff, edge_total_in;
   logic [bde_pkg::ETOT_W-1:0]  eidx_ff, eidx_in;
   logic [bde_pkg::CNT_W-1:0]   qhead_ff, qhead_in, qtail_ff, qtail_in;
   logic [NW-1:0]               cur_ff, cur_in, hnode_ff, hnode_in;
   logic [FW-1:0]               curd_ff, curd_in;
   logic [FW-1:0]               res_dist_ff, res_dist_in, res_reached_ff, res_reached_in;
   logic                        res_status_ff, res_status_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]               rsp_dist_ff, rsp_dist_in, rsp_reached_ff, rsp_reached_in;
   logic                        rsp_status_ff, rsp_status_in;

   logic [FW-1:0]  active_nodes;
   logic           from_ok, to_ok, src_ok, out_free, req_fire;
   logic [FW-1:0]  from_less, to_less, src_less;
   logic [NW-1:0]  e_tail, e_head;

   // Node counts above the memory size are saturated; a node is valid from one upwards.
   assign active_nodes = (cfg.node_count > bde_pkg::ACTIVE_MAX) ? bde_pkg::ACTIVE_MAX
                                                                : cfg.node_count;
   assign from_ok   = (req_from_node != '0) && (req_from_node <= active_nodes);
   assign to_ok     = (req_to_node != '0) && (req_to_node <= active_nodes);
   assign src_ok    = (cfg.source_node != '0) && (cfg.source_node <= active_nodes);
   assign from_less = req_from_node - FW'(1);
   assign to_less   = req_to_node - FW'(1);
   assign src_less  = cfg.source_node - FW'(1);
   assign e_tail    = edge_rdata_ff[2*NW-1:NW];
   assign e_head    = edge_rdata_ff[NW-1:0];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in       = state_ff;
      sweep_in       = sweep_ff;
      edge_total_in  = edge_total_ff;
      eidx_in        = eidx_ff;
      qhead_in       = qhead_ff;
      qtail_in       = qtail_ff;
      cur_in         = cur_ff;
      hnode_in       = hnode_ff;
      curd_in        = curd_ff;
      res_dist_in    = res_dist_ff;
      res_reached_in = res_reached_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_dist_in    = rsp_dist_ff;
      rsp_reached_in = rsp_reached_ff;
      rsp_status_in  = rsp_status_ff;
      dist_we        = 1'b0;
      dist_addr      = sweep_ff;
      dist_wdata     = bde_pkg::DIST_UNREACHABLE;
      queue_we       = 1'b0;
      queue_addr     = qhead_ff[NW-1:0];
      queue_wdata    = src_less[NW-1:0];
      edge_we        = 1'b0;
      edge_addr      = eidx_ff[bde_pkg::EDGE_IDX_W-1:0];
      edge_wdata     = {from_less[NW-1:0], to_less[NW-1:0]};

      unique case (state_ff)
         ST_INIT: begin
            dist_we  = 1'b1;
            sweep_in = sweep_ff + NW'(1);
            if (sweep_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               unique case (bde_pkg::kind_type'(req_kind))
                  bde_pkg::KIND_ADD_EDGE: begin
                     rsp_valid_in   = 1'b1;
                     rsp_dist_in    = '0;
                     rsp_reached_in = '0;
                     if (from_ok && to_ok && edge_total_ff < bde_pkg::EDGE_TOTAL_MAX) begin
                        edge_we       = 1'b1;
                        edge_addr     = edge_total_ff[bde_pkg::EDGE_IDX_W-1:0];
                        edge_total_in = edge_total_ff + bde_pkg::ETOT_W'(1);
                        rsp_status_in = 1'b0;
                     end else begin
                        rsp_status_in = 1'b1;
                     end
                  end
                  bde_pkg::KIND_RUN: begin
                     sweep_in = '0;
                     state_in = ST_CLR;
                  end
                  bde_pkg::KIND_READ: begin
                     if (from_ok) begin
                        dist_addr = from_less[NW-1:0];
                        state_in  = ST_READ;
                     end else begin
                        rsp_valid_in   = 1'b1;
                        rsp_dist_in    = bde_pkg::DIST_UNREACHABLE;
                        rsp_reached_in = '0;
                        rsp_status_in  = 1'b1;
                     end
                  end
                  bde_pkg::KIND_CLEAR: begin
                     edge_total_in  = '0;
                     rsp_valid_in   = 1'b1;
                     rsp_dist_in    = '0;
                     rsp_reached_in = '0;
                     rsp_status_in  = 1'b0;
                  end
               endcase
            end
         end
         ST_READ: begin
            res_dist_in    = dist_rdata_ff;
            res_reached_in = '0;
            res_status_in  = 1'b0;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_dist_in    = res_dist_ff;
               rsp_reached_in = res_reached_ff;
               rsp_status_in  = res_status_ff;
               state_in       = ST_IDLE;
            end
         end
         ST_CLR: begin
            dist_we  = 1'b1;
            sweep_in = sweep_ff + NW'(1);
            if (sweep_ff == '1) begin
               qhead_in = '0;
               qtail_in = '0;
               if (src_ok) begin
                  state_in = ST_SEED;
               end else begin
                  res_dist_in    = '0;
                  res_reached_in = '0;
                  res_status_in  = 1'b1;
                  state_in       = ST_DONE;
               end
            end
         end
         ST_SEED: begin
            dist_we    = 1'b1;
            dist_addr  = src_less[NW-1:0];
            dist_wdata = '0;
            queue_we   = 1'b1;
            queue_addr = '0;
            qtail_in   = bde_pkg::CNT_W'(1);
            state_in   = ST_POP;
         end
         ST_POP: begin
            if (qhead_ff == qtail_ff) begin
               res_dist_in    = '0;
               res_reached_in = FW'(qtail_ff);
               res_status_in  = 1'b0;
               state_in       = ST_DONE;
            end else begin
               qhead_in = qhead_ff + bde_pkg::CNT_W'(1);
               state_in = ST_POPW;
            end
         end
         ST_POPW: begin
            cur_in    = queue_rdata_ff;
            dist_addr = queue_rdata_ff;
            state_in  = ST_CURD;
         end
         ST_CURD: begin
            curd_in  = dist_rdata_ff;
            eidx_in  = '0;
            state_in = ST_EREAD;
         end
         ST_EREAD: begin
            if (eidx_ff == edge_total_ff) begin
               state_in = ST_POP;
            end else begin
               eidx_in  = eidx_ff + bde_pkg::ETOT_W'(1);
               state_in = ST_EWAIT;
            end
         end
         ST_EWAIT: begin
            // Edges whose head now lies beyond the node count are skipped.
            if (e_tail == cur_ff && FW'(e_head) < active_nodes) begin
               dist_addr = e_head;
               hnode_in  = e_head;
               state_in  = ST_HCHK;
            end else begin
               state_in = ST_EREAD;
            end
         end
         ST_HCHK: begin
            if (dist_rdata_ff == bde_pkg::DIST_UNREACHABLE && qtail_ff < bde_pkg::QUEUE_MAX) begin
               dist_we     = 1'b1;
               dist_addr   = hnode_ff;
               dist_wdata  = curd_ff + FW'(1);
               queue_we    = 1'b1;
               queue_addr  = qtail_ff[NW-1:0];
               queue_wdata = hnode_ff;
               qtail_in    = qtail_ff + bde_pkg::CNT_W'(1);
            end
            state_in = ST_EREAD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         sweep_ff      <= '0;
         edge_total_ff <= '0;
         qhead_ff      <= '0;
         qtail_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         edge_total_ff <= edge_total_in;
         qhead_ff      <= qhead_in;
         qtail_ff      <= qtail_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      eidx_ff        <= eidx_in;
      cur_ff         <= cur_in;
      hnode_ff       <= hnode_in;
      curd_ff        <= curd_in;
      res_dist_ff    <= res_dist_in;
      res_reached_ff <= res_reached_in;
      res_status_ff  <= res_status_in;
      rsp_dist_ff    <= rsp_dist_in;
      rsp_reached_ff <= rsp_reached_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_distance      = rsp_dist_ff;
   assign rsp_reached_count = rsp_reached_ff;
   assign rsp_status        = rsp_status_ff;

   `BDE_ASSERT(a_ready_only_idle, req_ready |-> (state_ff == ST_IDLE))
   `BDE_ASSERT(a_queue_order, qhead_ff <= qtail_ff)
   `BDE_NEVER(a_edge_bound, edge_total_ff > bde_pkg::EDGE_TOTAL_MAX)
   `BDE_ASSERT(a_done_loads, (state_ff == ST_DONE && !rsp_valid_ff) |=> rsp_valid_ff)
endmodule

>>> rtl/bde_csr.sv
// Configuration registers of the breadth-first search engine behind an APB-style port.
// Depends on bde_pkg.
module bde_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bde_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output bde_pkg::cfg_type              cfg
);
   logic [bde_pkg::FIELD_W-1:0] node_count_ff, node_count_in;
   logic [bde_pkg::FIELD_W-1:0] source_node_ff, source_node_in;
   logic                        wr_en;

   // Bits one and zero are ignored; bit two picks the register.
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      node_count_in  = node_count_ff;
      source_node_in = source_node_ff;
      if (wr_en) begin
         if (paddr[2] == bde_pkg::REG_NODE_COUNT) begin
            node_count_in = pwdata[bde_pkg::FIELD_W-1:0];
         end else begin
            source_node_in = pwdata[bde_pkg::FIELD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff  <= bde_pkg::NODE_COUNT_RST;
         source_node_ff <= bde_pkg::SOURCE_NODE_RST;
      end else begin
         node_count_ff  <= node_count_in;
         source_node_ff <= source_node_in;
      end
   end

   assign prdata = (paddr[2] == bde_pkg::REG_NODE_COUNT)
                   ? {{(32-bde_pkg::FIELD_W){1'b0}}, node_count_ff}
                   : {{(32-bde_pkg::FIELD_W){1'b0}}, source_node_ff};
   assign cfg.node_count  = node_count_ff;
   assign cfg.source_node = source_node_ff;
endmodule

>>> tb/bfs_distance_engine_checker.sv
// Checker for the breadth-first search engine: watches the command, result and register
// ports, predicts every result and compares it field by field. Depends on bde_pkg.
module bfs_distance_engine_checker
   import bde_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [1:0]                req_kind,
   input  logic [FIELD_W-1:0]        req_from_node,
   input  logic [FIELD_W-1:0]        req_to_node,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [FIELD_W-1:0]        rsp_distance,
   input  logic [FIELD_W-1:0]        rsp_reached_count,
   input  logic                      rsp_status,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]               csr_pwdata,
   input  logic                      csr_pready,
   output int                        fail_count,
   output int                        results_pending
);
   typedef struct {
      logic [FIELD_W-1:0] distance;
      logic [FIELD_W-1:0] reached;
      logic               status;
   } bfs_result_type;

   bfs_result_type awaited_results[$];
   int unsigned    node_limit;
   int unsigned    start_node;
   int unsigned    edge_tails [MAX_EDGES];
   int unsigned    edge_heads [MAX_EDGES];
   int unsigned    edges_held;
   int             hop_counts [MAX_NODES];
   int unsigned    walk_fifo  [MAX_NODES];

   assign results_pending = awaited_results.size();

   function automatic bit node_in_use(int unsigned n);
      int unsigned active;
      active = (node_limit > MAX_NODES) ? MAX_NODES : node_limit;
      return (n >= 1) && (n <= active);
   endfunction

   // Plain FIFO walk; edges are scanned in the order they were loaded.
   function automatic int unsigned walk_graph(output bit ok);
      int unsigned rd, wr, cur, head, reached;
      int          d;
      for (int i = 0; i < MAX_NODES; i++) hop_counts[i] = -1;
      ok = node_in_use(start_node);
      if (!ok) return 0;
      hop_counts[start_node - 1] = 0;
      walk_fifo[0] = start_node;
      rd = 0;
      wr = 1;
      reached = 1;
      while (rd < wr) begin
         cur = walk_fifo[rd];
         rd++;
         d = hop_counts[cur - 1];
         for (int unsigned e = 0; e < edges_held; e++) begin
            head = edge_heads[e];
            if (edge_tails[e] == cur && node_in_use(head) && hop_counts[head - 1] == -1 &&
                wr < MAX_NODES) begin
               hop_counts[head - 1] = d + 1;
               walk_fifo[wr] = head;
               wr++;
               reached++;
            end
         end
      end
      return reached;
   endfunction

   function automatic bfs_result_type predict_result(kind_type kind, int unsigned from_n,
                                                     int unsigned to_n);
      bfs_result_type r;
      bit             ok;
      int             d;
      d = 0;
      r.reached = '0;
      r.status = 1'b0;
      case (kind)
         KIND_ADD_EDGE: begin
            if (!node_in_use(from_n) || !node_in_use(to_n) || edges_held >= MAX_EDGES)
               r.status = 1'b1;
            else begin
               edge_tails[edges_held] = from_n;
               edge_heads[edges_held] = to_n;
               edges_held++;
            end
         end
         KIND_RUN: begin
            r.reached = FIELD_W'(walk_graph(ok));
            r.status = !ok;
         end
         KIND_READ: begin
            if (node_in_use(from_n)) d = hop_counts[from_n - 1];
            else begin
               d = -1;
               r.status = 1'b1;
            end
         end
         default: edges_held = 0;
      endcase
      r.distance = FIELD_W'(d);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [FIELD_W-1:0] got,
                                  logic [FIELD_W-1:0] want);
      $display("ERROR at %0t: %s got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      bfs_result_type want;
      bfs_result_type fresh;
      if (reset) begin
         fail_count = 0;
         node_limit = 32'(NODE_COUNT_RST);
         start_node = 32'(SOURCE_NODE_RST);
         edges_held = 0;
         for (int i = 0; i < MAX_NODES; i++) hop_counts[i] = -1;
         awaited_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_NODE_COUNT) node_limit = 32'(csr_pwdata[FIELD_W-1:0]);
            else start_node = 32'(csr_pwdata[FIELD_W-1:0]);
         end
         // A result leaving in the same cycle belongs to an earlier command.
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $display("ERROR at %0t: result with no command outstanding", $time);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_distance !== want.distance)
                  report_mismatch("distance", rsp_distance, want.distance);
               if (rsp_reached_count !== want.reached)
                  report_mismatch("reached_count", rsp_reached_count, want.reached);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
            end
         end
         if (req_valid && req_ready) begin
            fresh = predict_result(kind_type'(req_kind), 32'(req_from_node),
                                   32'(req_to_node));
            awaited_results.insert(awaited_results.size(), fresh);
         end
      end
   end
endmodule

>>> tb/bfs_distance_engine_tb.sv
// Top of the breadth-first search engine testbench: clock, reset, command stimulus,
// register writes and verdict. Depends on bde_pkg, bfs_distance_engine and the checker.
module bfs_distance_engine_tb;
   import bde_pkg::*;

   localparam int CYCLE_LIMIT = 20000000;
   localparam int TARGET_ITEMS = 1900;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_kind = KIND_READ;
   logic [FIELD_W-1:0]        req_from_node = '0;
   logic [FIELD_W-1:0]        req_to_node = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [FIELD_W-1:0] rsp_distance;
   logic [FIELD_W-1:0]        rsp_reached_count;
   logic                      rsp_status;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]     csr_paddr = '0;
   logic [31:0]               csr_pwdata = '0;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   int fail_count;
   int results_pending;
   int send_idle_pct;
   int recv_idle_pct;
   int cycle_count;
   int items_sent;
   int edges_loaded;
   int nodes_in_use;

   always #5 clock = ~clock;

   bfs_distance_engine dut (.*);

   bfs_distance_engine_checker checker_inst (
      .clock, .reset, .req_valid, .req_ready, .req_kind, .req_from_node, .req_to_node,
      .rsp_valid, .rsp_ready, .rsp_distance, .rsp_reached_count, .rsp_status,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .fail_count, .results_pending
   );

   // The receiver stalls at random at the rate of the present phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: a hung block or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Presents one command transaction and holds it until the block takes it. A gap is
   // opened first, at the sender's idle rate, so that valid drops between transactions.
   task automatic send_command(kind_type kind, int from_n, int to_n);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_from_node <= FIELD_W'(from_n);
      req_to_node <= FIELD_W'(to_n);
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (kind == KIND_ADD_EDGE) edges_loaded++;
      if (kind == KIND_CLEAR) edges_loaded = 0;
   endtask

   // Registers are only written with nothing in flight. Every command yields a result,
   // so once the last one has left the block is idle; the task then waits on as a margin.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // A write is a setup phase followed by an access phase.
   task automatic write_register(logic reg_index, logic [31:0] value);
      wait_until_drained();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {reg_index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      if (reg_index == REG_NODE_COUNT) nodes_in_use = value[FIELD_W-1:0];
   endtask

   // Mostly a node of the graph in use; now and then any 11-bit value, so that bad
   // nodes are tried and every bit of the field toggles.
   function automatic int pick_node();
      int top;
      top = (nodes_in_use > MAX_NODES) ? MAX_NODES : nodes_in_use;
      if (top < 1) top = 1;
      if ($urandom_range(99) < 85) return $urandom_range(top, 1);
      return $urandom_range(2047, 0);
   endfunction

   // Node count for a random episode: small graphs mostly keep the runs short.
   function automatic int pick_node_count();
      int sel;
      sel = $urandom_range(99);
      if (sel < 65) return $urandom_range(40, 2);
      if (sel < 75) return MAX_NODES;
      if (sel < 80) return 0;
      if (sel < 85) return 1;
      if (sel < 92) return $urandom_range(2047, 1025);
      return $urandom_range(1023, 41);
   endfunction

   // One episode: optional new settings, optional clear, a batch of edges, a search and
   // some reads, with a sprinkling of stray commands.
   task automatic random_episode();
      int n_edges;
      int n_reads;
      if ($urandom_range(99) < 30) begin
         write_register(REG_NODE_COUNT, {$urandom_range(1) ? 21'($urandom) : 21'd0,
                                         11'(pick_node_count())});
         write_register(REG_SOURCE_NODE, 32'(pick_node()));
      end
      if ($urandom_range(99) < 50 || edges_loaded > 60) send_command(KIND_CLEAR, pick_node(),
                                                                     pick_node());
      n_edges = $urandom_range(24, 1);
      for (int i = 0; i < n_edges; i++) send_command(KIND_ADD_EDGE, pick_node(), pick_node());
      send_command(KIND_RUN, $urandom_range(2047, 0), $urandom_range(2047, 0));
      n_reads = $urandom_range(8, 1);
      for (int i = 0; i < n_reads; i++) begin
         if ($urandom_range(99) < 10)
            send_command(kind_type'($urandom_range(3, 0)), pick_node(), pick_node());
         else
            send_command(KIND_READ, pick_node(), $urandom_range(2047, 0));
      end
   endtask

   initial begin
      cycle_count = 0;
      items_sent = 0;
      edges_loaded = 0;
      nodes_in_use = MAX_NODES;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Reads straight after reset see every node unreachable, and the
      // bad read nodes are zero, just above the count and the largest field value.
      send_command(KIND_READ, 1, 0);
      send_command(KIND_READ, 0, 2047);
      send_command(KIND_READ, MAX_NODES, 0);
      send_command(KIND_READ, MAX_NODES + 1, 0);
      send_command(KIND_READ, 2047, 0);
      // Bad edge nodes are refused, good ones build a chain 1, 2, 1024, 3.
      send_command(KIND_ADD_EDGE, 0, 1);
      send_command(KIND_ADD_EDGE, 1, 0);
      send_command(KIND_ADD_EDGE, 1, MAX_NODES + 1);
      send_command(KIND_ADD_EDGE, 1, 2);
      send_command(KIND_ADD_EDGE, 2, MAX_NODES);
      send_command(KIND_ADD_EDGE, MAX_NODES, 3);
      send_command(KIND_ADD_EDGE, 3, 1);
      send_command(KIND_RUN, 0, 0);
      send_command(KIND_READ, MAX_NODES, 0);
      send_command(KIND_READ, 3, 0);
      // Shrinking the graph leaves edges to node 1024 stale, so the walk stops early.
      write_register(REG_NODE_COUNT, 2);
      send_command(KIND_RUN, 0, 0);
      send_command(KIND_READ, 2, 0);
      // A source above the node count still wipes the distances.
      write_register(REG_SOURCE_NODE, 5);
      send_command(KIND_RUN, 0, 0);
      send_command(KIND_READ, 1, 0);
      // Clearing keeps the distances of the last search.
      send_command(KIND_CLEAR, 0, 0);
      send_command(KIND_READ, 1, 0);
      // A node count of zero puts every node out of range.
      write_register(REG_NODE_COUNT, 0);
      send_command(KIND_RUN, 0, 0);
      send_command(KIND_READ, 1, 0);
      send_command(KIND_ADD_EDGE, 1, 1);
      // Above the maximum the count saturates; upper data bits are dropped.
      write_register(REG_NODE_COUNT, 32'hFFFF_FFFF);
      write_register(REG_SOURCE_NODE, 32'h0001_0001);
      send_command(KIND_READ, MAX_NODES, 0);
      // A short graph from node 1, searched once more, then emptied.
      send_command(KIND_ADD_EDGE, 1, 2);
      send_command(KIND_ADD_EDGE, 2, 3);
      send_command(KIND_RUN, 0, 0);
      send_command(KIND_READ, 3, 0);
      send_command(KIND_CLEAR, 0, 0);

      // Random part in three phases of idling.
      send_idle_pct = 36;
      recv_idle_pct = 64;
      while (items_sent < TARGET_ITEMS / 3) random_episode();
      send_idle_pct = 64;
      recv_idle_pct = 36;
      while (items_sent < 2 * TARGET_ITEMS / 3) random_episode();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (items_sent < TARGET_ITEMS) random_episode();

      // Drain, then allow some slack for anything stray to show up.
      wait_until_drained();
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

>>> filelist.f
+incdir+rtl
rtl/bde_pkg.sv
rtl/bde_csr.sv
rtl/bfs_distance_engine.sv
tb/bfs_distance_engine_checker.sv
tb/bfs_distance_engine_tb.sv
